### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_HOLDS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
	else $error("assertion failed: condition does not hold");

// General property checked on clk, disabled during reset.
`define ASSERT_PROP(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("assertion failed: property violated");

`endif

### design/ffpa_pkg.sv
package ffpa_pkg;

	localparam int PAGES      = 1024;
	localparam int PAGE_SHIFT = 12;
	localparam int IDX_W      = $clog2(PAGES);
	localparam int CNT_W      = $clog2(PAGES + 1);
	localparam int ADDR_W     = 32;
	localparam int SIZE_W     = 32;
	localparam int HEAP_W     = ADDR_W + 1;
	localparam int PNUM_W     = ADDR_W - PAGE_SHIFT;
	localparam int COUNT_W    = 11;
	localparam int STATUS_W   = 2;

	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 48;

	localparam logic [HEAP_W-1:0] HEAP_BYTES = HEAP_W'(PAGES) << PAGE_SHIFT;
	localparam logic [HEAP_W-1:0] PAGE_MASK  = (HEAP_W'(1) << PAGE_SHIFT) - HEAP_W'(1);

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_DONE     = 2'd0;
	localparam status_t ST_NO_SPACE = 2'd1;
	localparam status_t ST_BAD_SIZE = 2'd2;
	localparam status_t ST_BAD_FREE = 2'd3;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef struct packed {
		logic    clr;
		logic    latch;
		logic    scan;
		logic    mark;
		logic    free_start;
		logic    unmark;
		logic    res_load;
		status_t res_status;
	} cmd_t;

	typedef struct packed {
		logic kind_free;
		logic bad_size;
		logic no_room;
		logic bad_free;
		logic len_zero;
		logic hit;
		logic scan_end;
		logic rem_one;
		logic ptr_last;
		logic out_free;
	} sts_t;

endpackage

### design/ffpa_ram.sv
module ffpa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/ffpa_dp.sv
`include "assert_macros.svh"

module ffpa_dp import ffpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              cfg_wen,
	input  logic [ADDR_W-1:0] cfg_wdata,
	input  logic              in_kind,
	input  logic [SIZE_W-1:0] in_size,
	input  logic [ADDR_W-1:0] in_addr,
	input  logic              out_tready,
	output logic              out_valid,
	output status_t           out_status,
	output logic [ADDR_W-1:0] out_addr,
	output logic [COUNT_W-1:0] out_count
);

	logic [ADDR_W-1:0] heap_base_q;
	logic              kind_q;
	logic [CNT_W-1:0]  need_q;
	logic              bad_size_q;
	logic [ADDR_W-1:0] addr_q;

	logic [CNT_W-1:0]  ptr_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  start_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  len_q;
	logic [CNT_W-1:0]  busy_q;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [CNT_W-1:0]  out_count_q;

	logic [HEAP_W-1:0] need_sum;
	logic [HEAP_W-1:0] need_full;
	logic [ADDR_W-1:0] off;
	logic [PNUM_W-1:0] page_no;
	logic [IDX_W-1:0]  free_idx;
	logic              bad_free;
	logic              no_room;

	logic              busy_rdata;
	logic [CNT_W-1:0]  len_rdata;
	logic [CNT_W-1:0]  cnt_inc;
	logic [CNT_W-1:0]  start_w;
	logic [IDX_W-1:0]  start_calc;
	logic              hit;
	logic              scan_end;
	logic              issue;
	logic              ptr_last;

	logic              busy_we;
	logic              len_we;
	logic [IDX_W-1:0]  len_waddr;
	logic [CNT_W-1:0]  len_wdata;
	logic              res_done;

	// request decode
	assign need_sum  = {1'b0, in_size} + PAGE_MASK;
	assign need_full = need_sum >> PAGE_SHIFT;

	assign off      = addr_q - heap_base_q;
	assign page_no  = off[ADDR_W-1:PAGE_SHIFT];
	assign free_idx = off[PAGE_SHIFT +: IDX_W];
	assign bad_free = (|off[PAGE_SHIFT-1:0]) || (page_no >= PNUM_W'(PAGES));
	assign no_room  = need_q > (CNT_W'(PAGES) - busy_q);

	// first-fit scan, one map entry per cycle
	assign cnt_inc    = cnt_q + CNT_W'(1);
	assign start_w    = CNT_W'(idx_s1) + CNT_W'(1) - need_q;
	assign start_calc = start_w[IDX_W-1:0];
	assign hit        = cmd.scan && vld_s1 && !busy_rdata && (cnt_inc == need_q);
	assign scan_end   = cmd.scan && vld_s1 && (idx_s1 == IDX_W'(PAGES - 1)) && !hit;
	assign issue      = cmd.scan && (ptr_q != CNT_W'(PAGES));
	assign ptr_last   = ptr_q[IDX_W-1:0] == IDX_W'(PAGES - 1);

	assign busy_we = cmd.clr || cmd.mark || cmd.unmark;

	always_comb begin
		len_we    = cmd.clr || hit || cmd.free_start;
		len_waddr = ptr_q[IDX_W-1:0];
		len_wdata = '0;
		if (hit) begin
			len_waddr = start_calc;
			len_wdata = need_q;
		end else if (cmd.free_start) begin
			len_waddr = free_idx;
		end
	end

	ffpa_ram #(
		.WIDTH(1),
		.DEPTH(PAGES)
	) u_busy_ram (
		.clk  (clk),
		.we   (busy_we),
		.waddr(ptr_q[IDX_W-1:0]),
		.wdata(cmd.mark),
		.raddr(ptr_q[IDX_W-1:0]),
		.rdata(busy_rdata)
	);

	ffpa_ram #(
		.WIDTH(CNT_W),
		.DEPTH(PAGES)
	) u_len_ram (
		.clk  (clk),
		.we   (len_we),
		.waddr(len_waddr),
		.wdata(len_wdata),
		.raddr(free_idx),
		.rdata(len_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= '0;
		end else if (cfg_wen) begin
			heap_base_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q     <= in_kind;
			need_q     <= need_full[CNT_W-1:0];
			bad_size_q <= (in_size == '0) || ({1'b0, in_size} > HEAP_BYTES);
			addr_q     <= in_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			vld_s1  <= 1'b0;
			idx_s1  <= '0;
			cnt_q   <= '0;
			start_q <= '0;
			rem_q   <= '0;
			len_q   <= '0;
		end else if (cmd.latch) begin
			ptr_q  <= '0;
			vld_s1 <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.clr) begin
			ptr_q <= ptr_q + CNT_W'(1);
		end else if (cmd.scan) begin
			if (hit) begin
				// jump to the run start and mark from there
				ptr_q   <= CNT_W'(start_calc);
				rem_q   <= need_q;
				start_q <= start_calc;
				vld_s1  <= 1'b0;
			end else begin
				vld_s1 <= issue;
				if (issue) begin
					ptr_q  <= ptr_q + CNT_W'(1);
					idx_s1 <= ptr_q[IDX_W-1:0];
				end
				if (vld_s1) begin
					cnt_q <= busy_rdata ? '0 : cnt_inc;
				end
			end
		end else if (cmd.free_start) begin
			ptr_q <= CNT_W'(free_idx);
			rem_q <= len_rdata;
			len_q <= len_rdata;
		end else if (cmd.mark || cmd.unmark) begin
			ptr_q <= ptr_q + CNT_W'(1);
			rem_q <= rem_q - CNT_W'(1);
		end
	end

	assign res_done = cmd.res_status == ST_DONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
			if (res_done) begin
				if (kind_q == KIND_ALLOC) begin
					busy_q <= busy_q + need_q;
				end else begin
					busy_q <= (busy_q >= len_q) ? busy_q - len_q : '0;
				end
			end
		end else if (out_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_status_q <= cmd.res_status;
			out_addr_q   <= '0;
			out_count_q  <= '0;
			if (res_done) begin
				if (kind_q == KIND_ALLOC) begin
					out_addr_q  <= heap_base_q + (ADDR_W'(start_q) << PAGE_SHIFT);
					out_count_q <= need_q;
				end else begin
					out_count_q <= len_q;
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_addr   = out_addr_q;
	assign out_count  = COUNT_W'(out_count_q);

	always_comb begin
		sts           = '0;
		sts.kind_free = kind_q == KIND_FREE;
		sts.bad_size  = bad_size_q;
		sts.no_room   = no_room;
		sts.bad_free  = bad_free;
		sts.len_zero  = len_rdata == '0;
		sts.hit       = hit;
		sts.scan_end  = scan_end;
		sts.rem_one   = rem_q == CNT_W'(1);
		sts.ptr_last  = ptr_last;
		sts.out_free  = !out_valid_q || out_tready;
	end

	`ASSERT_HOLDS(a_busy_bounded, busy_q <= CNT_W'(PAGES))
	`ASSERT_PROP(a_mark_has_rem, ((cmd.mark || cmd.unmark) |-> (rem_q != '0)))

endmodule

### design/ffpa_ctrl.sv
`include "assert_macros.svh"

module ffpa_ctrl import ffpa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_tvalid,
	output logic in_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] S_CLEAR    = 3'd0;
	localparam logic [2:0] S_IDLE     = 3'd1;
	localparam logic [2:0] S_DECODE   = 3'd2;
	localparam logic [2:0] S_SCAN     = 3'd3;
	localparam logic [2:0] S_MARK     = 3'd4;
	localparam logic [2:0] S_FREE_CHK = 3'd5;
	localparam logic [2:0] S_UNMARK   = 3'd6;
	localparam logic [2:0] S_RESP     = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	status_t    code_q;
	status_t    code_d;

	always_comb begin
		state_d   = state_q;
		code_d    = code_q;
		cmd       = '0;
		in_tready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.ptr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_tready = 1'b1;
				if (in_tvalid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				if (!sts.kind_free) begin
					if (sts.bad_size) begin
						code_d  = ST_BAD_SIZE;
						state_d = S_RESP;
					end else if (sts.no_room) begin
						code_d  = ST_NO_SPACE;
						state_d = S_RESP;
					end else begin
						state_d = S_SCAN;
					end
				end else if (sts.bad_free) begin
					code_d  = ST_BAD_FREE;
					state_d = S_RESP;
				end else begin
					// recorded length is read this cycle
					state_d = S_FREE_CHK;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					state_d = S_MARK;
				end else if (sts.scan_end) begin
					code_d  = ST_NO_SPACE;
					state_d = S_RESP;
				end
			end
			S_MARK: begin
				cmd.mark = 1'b1;
				if (sts.rem_one) begin
					code_d  = ST_DONE;
					state_d = S_RESP;
				end
			end
			S_FREE_CHK: begin
				if (sts.len_zero) begin
					code_d  = ST_BAD_FREE;
					state_d = S_RESP;
				end else begin
					cmd.free_start = 1'b1;
					state_d        = S_UNMARK;
				end
			end
			S_UNMARK: begin
				cmd.unmark = 1'b1;
				if (sts.rem_one || sts.ptr_last) begin
					code_d  = ST_DONE;
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				// hold until the output register can take the result
				if (sts.out_free) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = code_q;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			code_q  <= ST_DONE;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	`ASSERT_HOLDS(a_cmd_onehot, $onehot0({cmd.clr, cmd.latch, cmd.scan, cmd.mark, cmd.free_start, cmd.unmark, cmd.res_load}))
	`ASSERT_PROP(a_resp_to_idle, (cmd.res_load |=> (state_q == S_IDLE)))

endmodule

### design/first_fit_page_allocator.sv
// An allocate decodes, scans the busy map first-fit and marks the run, or answers no
// space if no fit is found; a free decodes, reads the recorded run length and unmarks
// the run. Bad size, no room and a bad free address answer from decode, and a free of
// a page with no recorded run answers after the length read. One request is in flight;
// the next is taken in the cycle after the result loads, and a stalled output holds the
// input off. Reset: arst_n clears control state and heap_base, then a clearing pass.
module first_fit_page_allocator import ffpa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [ADDR_W-1:0]      cfg_wdata,     // heap_base
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // size_bytes[31:0], address[63:32]
	input  logic                   s_axis_tuser,  // kind
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // result_address[31:0], page_count[42:32]
	output logic [STATUS_W-1:0]    m_axis_tuser   // status
);

	localparam int PAD_W = OUT_TDATA_W - ADDR_W - COUNT_W;

	cmd_t              cmd;
	sts_t              sts;
	status_t           out_status;
	logic [ADDR_W-1:0] out_addr;
	logic [COUNT_W-1:0] out_count;

	ffpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_tvalid(s_axis_tvalid),
		.in_tready(s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffpa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_kind   (s_axis_tuser),
		.in_size   (s_axis_tdata[SIZE_W-1:0]),
		.in_addr   (s_axis_tdata[SIZE_W +: ADDR_W]),
		.out_tready(m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_status(out_status),
		.out_addr  (out_addr),
		.out_count (out_count)
	);

	assign m_axis_tdata = {{PAD_W{1'b0}}, out_count, out_addr};
	assign m_axis_tuser = out_status;

endmodule
